### hw/rtl/aspd_pkg.sv
// ----------------------------------------------------------------------------
// AS_PATH segment decoder package
// Shared types and constants for the AS_PATH segment decoder.
// ----------------------------------------------------------------------------
package aspd_pkg;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_COUNT,
    PH_ASN
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  localparam logic [7:0]  SEG_AS_SET   = 8'd1;
  localparam logic [15:0] MIN_ATTR_LEN = 16'd4;
  localparam logic [15:0] MIN_HDR_LEFT = 16'd2;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] attr_length;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic        asn_valid;
    logic [31:0] asn_value;
    logic        in_set;
    logic        done_res;
    logic [15:0] as_count;
    logic        origin_valid;
    logic [31:0] origin_asn;
    logic [1:0]  status;
  } result_t;

endpackage

### hw/rtl/as_path_segment_decoder.sv
// ----------------------------------------------------------------------------
// AS_PATH segment decoder
// Decodes an AS_PATH attribute value byte by byte into ASNs and a summary.
// ----------------------------------------------------------------------------
// The decoder accepts one attribute byte per clock cycle while data_stall is
// low, and returns at most one result transaction per byte. The byte is held
// in the input register, and its result is loaded into the result register
// when the walker advances; it stays there until it is taken. The segment
// walk state is updated once for each byte that the walker takes, which sets
// this rate. A result transaction that waits under result_stall stalls the
// input only when the byte behind it reaches the walker. The ASN width
// register may be written at any time through the configuration channel,
// which is always ready; it should change only while no attribute is in
// flight.
module as_path_segment_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        asn_four_octets,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [15:0] attr_length,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        asn_valid,
  output logic [31:0] asn_value,
  output logic        in_set,
  output logic        done_res,
  output logic [15:0] as_count,
  output logic        origin_valid,
  output logic [31:0] origin_asn,
  output logic [1:0]  status
);
  import aspd_pkg::*;

  logic    four_octets;
  logic    item_valid;
  item_t   item;
  logic    res_valid;
  result_t res;

  logic    res_open;
  logic    advance;
  logic    produce;
  result_t step_result;

  assign cfg_ready  = 1'b1;
  assign res_open   = !res_valid || !result_stall;
  assign advance    = item_valid && res_open;
  assign data_stall = item_valid && !res_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_octets <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      four_octets <= asn_four_octets;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!data_stall) begin
      item_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      item <= '{data_byte: data_byte, first_byte: first_byte,
                attr_length: attr_length, last_byte: last_byte};
    end
  end

  aspd_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .four_octets (four_octets),
    .item_en     (advance),
    .item        (item),
    .produce     (produce),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_open) begin
      res_valid <= advance && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      res <= step_result;
    end
  end

  assign result_valid = res_valid;
  assign asn_valid    = res.asn_valid;
  assign asn_value    = res.asn_value;
  assign in_set       = res.in_set;
  assign done_res     = res.done_res;
  assign as_count     = res.as_count;
  assign origin_valid = res.origin_valid;
  assign origin_asn   = res.origin_asn;
  assign status       = res.status;

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (asn_valid || done_res))
    else $error("Result transaction carries neither an ASN nor a summary.");

  a_asn_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !asn_valid) |-> (asn_value == '0 && !in_set))
    else $error("ASN fields are set on a result without an ASN.");

  a_origin_consistent: assert property (@(posedge clk) disable iff (rst)
    (result_valid && done_res) |-> ((as_count == '0) == !origin_valid))
    else $error("Origin flag disagrees with the ASN count.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> (item_valid && res_valid && result_stall))
    else $error("Input stalled while the result register could advance.");

endmodule

### hw/rtl/aspd_walk.sv
// ----------------------------------------------------------------------------
// AS_PATH segment walker
// Holds the segment walk state and decodes one attribute byte per cycle while item_en is high.
// ----------------------------------------------------------------------------
module aspd_walk (
  input  logic            clk,
  input  logic            rst,
  input  logic            four_octets,
  input  logic            item_en,
  input  aspd_pkg::item_t item,
  output logic            produce,
  output aspd_pkg::result_t result
);
  import aspd_pkg::*;

  phase_t      phase;
  logic [15:0] bytes_left;
  logic        set_segment;
  logic [7:0]  asns_left;
  logic [1:0]  octet_index;
  logic [31:0] asn_acc;
  logic [15:0] asn_total;
  logic [31:0] last_asn;
  logic        have_asn;
  logic [1:0]  error_code;

  phase_t      phase_next;
  logic [15:0] bytes_left_next;
  logic        set_segment_next;
  logic [7:0]  asns_left_next;
  logic [1:0]  octet_index_next;
  logic [31:0] asn_acc_next;
  logic [15:0] asn_total_next;
  logic [31:0] last_asn_next;
  logic        have_asn_next;
  logic [1:0]  error_code_next;

  always_comb begin
    logic [9:0]  seg_bytes;
    logic [1:0]  octet_inc;
    logic [1:0]  size_code;
    logic [31:0] acc_shift;
    logic        emit;

    phase_next       = phase;
    bytes_left_next  = bytes_left;
    set_segment_next = set_segment;
    asns_left_next   = asns_left;
    octet_index_next = octet_index;
    asn_acc_next     = asn_acc;
    asn_total_next   = asn_total;
    last_asn_next    = last_asn;
    have_asn_next    = have_asn;
    error_code_next  = error_code;
    emit             = 1'b0;
    result           = '0;

    seg_bytes = four_octets ? {item.data_byte, 2'b00} : {1'b0, item.data_byte, 1'b0};
    size_code = four_octets ? 2'd0 : 2'd2;

    if (item.first_byte) begin
      phase_next       = PH_TYPE;
      bytes_left_next  = '0;
      set_segment_next = 1'b0;
      asns_left_next   = '0;
      octet_index_next = '0;
      asn_acc_next     = '0;
      asn_total_next   = '0;
      last_asn_next    = '0;
      have_asn_next    = 1'b0;
      error_code_next  = ST_OK;
      if (item.attr_length < MIN_ATTR_LEN) begin
        error_code_next = ST_SHORT;
      end else begin
        bytes_left_next = item.attr_length;
      end
    end

    acc_shift = {asn_acc_next[23:0], item.data_byte};
    octet_inc = octet_index_next + 2'd1;

    if (error_code_next == ST_OK && bytes_left_next != '0) begin
      unique case (phase_next)
        PH_COUNT: begin
          bytes_left_next = bytes_left_next - 16'd1;
          asns_left_next  = item.data_byte;
          if ({6'b0, seg_bytes} > bytes_left_next) begin
            error_code_next = ST_OVERRUN;
          end else if (item.data_byte == '0) begin
            phase_next = PH_TYPE;
          end else begin
            phase_next       = PH_ASN;
            octet_index_next = '0;
            asn_acc_next     = '0;
          end
        end
        PH_ASN: begin
          bytes_left_next = bytes_left_next - 16'd1;
          if (octet_inc == size_code) begin
            emit             = 1'b1;
            result.asn_value = acc_shift;
            result.in_set    = set_segment_next;
            last_asn_next    = acc_shift;
            have_asn_next    = 1'b1;
            if (asn_total_next != COUNT_MAX) begin
              asn_total_next = asn_total_next + 16'd1;
            end
            octet_index_next = '0;
            asn_acc_next     = '0;
            asns_left_next   = asns_left_next - 8'd1;
            if (asns_left_next == '0) begin
              phase_next = PH_TYPE;
            end
          end else begin
            asn_acc_next     = acc_shift;
            octet_index_next = octet_inc;
          end
        end
        default: begin
          if (bytes_left_next < MIN_HDR_LEFT) begin
            error_code_next = ST_OVERRUN;
          end else begin
            bytes_left_next  = bytes_left_next - 16'd1;
            set_segment_next = (item.data_byte == SEG_AS_SET);
            phase_next       = PH_COUNT;
          end
        end
      endcase
    end

    result.asn_valid = emit;
    if (item.last_byte) begin
      result.done_res     = 1'b1;
      result.as_count     = asn_total_next;
      result.origin_valid = have_asn_next;
      result.origin_asn   = have_asn_next ? last_asn_next : '0;
      if (error_code_next == ST_OK && bytes_left_next != '0) begin
        result.status = ST_TRUNC;
      end else begin
        result.status = error_code_next;
      end
      phase_next       = PH_TYPE;
      bytes_left_next  = '0;
      set_segment_next = 1'b0;
      asns_left_next   = '0;
      octet_index_next = '0;
      asn_acc_next     = '0;
      asn_total_next   = '0;
      last_asn_next    = '0;
      have_asn_next    = 1'b0;
      error_code_next  = ST_OK;
    end
    produce = emit || item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      bytes_left  <= '0;
      set_segment <= 1'b0;
      asns_left   <= '0;
      octet_index <= '0;
      asn_acc     <= '0;
      asn_total   <= '0;
      last_asn    <= '0;
      have_asn    <= 1'b0;
      error_code  <= ST_OK;
    end else if (item_en) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      set_segment <= set_segment_next;
      asns_left   <= asns_left_next;
      octet_index <= octet_index_next;
      asn_acc     <= asn_acc_next;
      asn_total   <= asn_total_next;
      last_asn    <= last_asn_next;
      have_asn    <= have_asn_next;
      error_code  <= error_code_next;
    end
  end

endmodule
